@@ design/gbm_pkg.sv @@
// Package for the geofence breach monitor.
// Holds field widths, register indexes, fence mode and breach action codes.
// No dependencies.
`default_nettype none

package gbm_pkg;

  localparam int unsigned PosW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CodeW = 2;

  localparam int unsigned BreachTicks = 2;
  localparam int unsigned CntW = $clog2(BreachTicks + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(BreachTicks);

  localparam logic signed [PosW-1:0] XMinRst = -24'sd1024;
  localparam logic signed [PosW-1:0] YMinRst = -24'sd1024;
  localparam logic signed [PosW-1:0] ZMinRst = -24'sd8388608;
  localparam logic signed [PosW-1:0] XMaxRst = 24'sd1024;
  localparam logic signed [PosW-1:0] YMaxRst = 24'sd1024;
  localparam logic signed [PosW-1:0] ZMaxRst = 24'sd8388607;

  typedef enum logic [CfgIdxW-1:0] {
    RegXMin   = 3'd0,
    RegYMin   = 3'd1,
    RegZMin   = 3'd2,
    RegXMax   = 3'd3,
    RegYMax   = 3'd4,
    RegZMax   = 3'd5,
    RegMode   = 3'd6,
    RegAction = 3'd7
  } cfg_reg_e;

  typedef enum logic [CodeW-1:0] {
    ModeDisabled  = 2'd0,
    ModeUnlimited = 2'd1,
    ModeAlways    = 2'd2,
    ModeBox       = 2'd3
  } fence_mode_e;

  typedef enum logic [CodeW-1:0] {
    ActNone     = 2'd0,
    ActStop     = 2'd1,
    ActShutdown = 2'd2,
    ActLand     = 2'd3
  } breach_action_e;

endpackage

`default_nettype wire

@@ design/gbm_if.sv @@
// Handshake channels of the geofence breach monitor: samples, results and
// configuration writes. Depends on gbm_pkg.
`default_nettype none

interface gbm_sample_if
  import gbm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic                   is_flying;

  modport source (output valid, pos_x, pos_y, pos_z, is_flying, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, is_flying, output ready);
endinterface

interface gbm_result_if;
  logic valid;
  logic ready;
  logic inside_fence;
  logic breached;
  logic block_motors;
  logic request_shutdown;

  modport source (output valid, inside_fence, breached, block_motors,
                  request_shutdown, input ready);
  modport sink (input valid, inside_fence, breached, block_motors,
                request_shutdown, output ready);
endinterface

interface gbm_cfg_if
  import gbm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/geofence_breach_monitor_core.sv @@
// Geofence breach monitor: checks position samples against a fence box.
// Depends on gbm_pkg and the channel interfaces in gbm_if.sv.
//
// Usage:
//   sample_i carries one position beat (x, y, z at 1/1024 m, flying flag).
//   result_o returns one beat per sample: inside flag, breach flag and the
//   motor-block and shutdown requests for that sample, in sample order.
//   cfg_i writes one of eight registers (box bounds, fence mode, breach
//   action); it is always ready, and every write clears the breach state.
//   The user must write configuration only while no sample is in flight;
//   the block itself does not enforce this.
// Pipeline and throughput:
//   A sample is registered at acceptance, evaluated from the input register
//   and its result is held in the output register. One sample per cycle is
//   sustained while result_o is ready. The input and output registers let
//   one more sample be taken while a result waits on a stalled receiver.
// Reset:
//   rst_ni clears the valid flags of both beat registers, the outside counter and the breach
//   flag, and loads the default box with the fence disabled.
`default_nettype none

module geofence_breach_monitor_core
  import gbm_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  gbm_sample_if.sink    sample_i,
  gbm_result_if.source  result_o,
  gbm_cfg_if.sink       cfg_i
);

  logic signed [PosW-1:0] x_min_q, y_min_q, z_min_q;
  logic signed [PosW-1:0] x_max_q, y_max_q, z_max_q;
  fence_mode_e            mode_q;
  breach_action_e         action_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            breach_q, breach_d;

  logic                   s1_valid_q;
  logic signed [PosW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                   s1_fly_q;

  logic out_valid_q;
  logic out_inside_q, out_breach_q, out_stop_q, out_shut_q;

  logic advance, sample_acc, cfg_acc;
  logic in_box, in_fence, act, stop, shut;

  assign advance    = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_acc = sample_i.valid && sample_i.ready;
  assign cfg_acc    = cfg_i.valid && cfg_i.ready;

  assign sample_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready    = 1'b1;

  assign in_box = (s1_x_q >= x_min_q) && (s1_x_q <= x_max_q) &&
                  (s1_y_q >= y_min_q) && (s1_y_q <= y_max_q) &&
                  (s1_z_q >= z_min_q) && (s1_z_q <= z_max_q);

  always_comb begin
    unique case (mode_q)
      ModeDisabled:  in_fence = 1'b1;
      ModeUnlimited: in_fence = 1'b1;
      ModeAlways:    in_fence = 1'b0;
      ModeBox:       in_fence = in_box;
      default:       in_fence = 1'b1;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    breach_d = breach_q;
    act      = 1'b0;
    if (in_fence) begin
      cnt_d    = '0;
      breach_d = 1'b0;
    end else if (cnt_q < CntMax) begin
      cnt_d = cnt_q + CntW'(1);
    end else begin
      breach_d = 1'b1;
      act      = 1'b1;
    end
  end

  assign stop = act && s1_fly_q && (action_q == ActStop);
  assign shut = act && s1_fly_q && (action_q == ActShutdown);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= XMinRst;
      y_min_q  <= YMinRst;
      z_min_q  <= ZMinRst;
      x_max_q  <= XMaxRst;
      y_max_q  <= YMaxRst;
      z_max_q  <= ZMaxRst;
      mode_q   <= ModeDisabled;
      action_q <= ActNone;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegXMin:   x_min_q  <= cfg_i.data;
        RegYMin:   y_min_q  <= cfg_i.data;
        RegZMin:   z_min_q  <= cfg_i.data;
        RegXMax:   x_max_q  <= cfg_i.data;
        RegYMax:   y_max_q  <= cfg_i.data;
        RegZMax:   z_max_q  <= cfg_i.data;
        RegMode:   mode_q   <= fence_mode_e'(cfg_i.data[CodeW-1:0]);
        RegAction: action_q <= breach_action_e'(cfg_i.data[CodeW-1:0]);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      breach_q <= 1'b0;
    end else if (cfg_acc) begin
      cnt_q    <= '0;
      breach_q <= 1'b0;
    end else if (advance) begin
      cnt_q    <= cnt_d;
      breach_q <= breach_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_acc) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      s1_x_q   <= sample_i.pos_x;
      s1_y_q   <= sample_i.pos_y;
      s1_z_q   <= sample_i.pos_z;
      s1_fly_q <= sample_i.is_flying;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_inside_q <= in_fence;
      out_breach_q <= breach_d;
      out_stop_q   <= stop;
      out_shut_q   <= shut;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.inside_fence     = out_inside_q;
  assign result_o.breached         = out_breach_q;
  assign result_o.block_motors     = out_stop_q;
  assign result_o.request_shutdown = out_shut_q;

`ifndef SYNTHESIS
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_stop_q && out_shut_q))
    else $error("Motor stop and shutdown requested on the same beat.");

  a_action_needs_breach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stop_q || out_shut_q)) |-> out_breach_q)
    else $error("Breach action requested without a breach.");

  a_breach_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_breach_q) |-> !out_inside_q)
    else $error("Breach reported on a sample inside the fence.");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (!breach_q && (cnt_q == '0)))
    else $error("Configuration write did not clear the breach state.");
`endif

endmodule

`default_nettype wire

@@ dv/geofence_breach_monitor_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for geofence_breach_monitor_core: a table of directed beats, then
// random fences and positions under changing backpressure, scored against an in-bench model.
// Depends on gbm_pkg, the channel interfaces in gbm_if.sv and the core itself.

module geofence_breach_monitor_core_tb;
  import gbm_pkg::*;

  localparam int PosMin = -8388608;
  localparam int PosMax = 8388607;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned PhaseBeats = 667;
  localparam int unsigned LongHold = 300;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic                   flying;
  } sample_t;

  typedef struct packed {
    logic inside_fence;
    logic breached;
    logic block_motors;
    logic request_shutdown;
  } verdict_t;

  typedef struct {
    bit       pinned;
    verdict_t want;
  } pin_t;

  typedef struct {
    bit                  is_cfg;
    cfg_reg_e            reg_idx;
    logic [CfgDataW-1:0] wdata;
    sample_t             smp;
    bit                  pinned;
    verdict_t            want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  gbm_sample_if sample_ch ();
  gbm_result_if result_ch ();
  gbm_cfg_if    cfg_ch ();

  geofence_breach_monitor_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  logic signed [PosW-1:0] box_lo [3];
  logic signed [PosW-1:0] box_hi [3];
  fence_mode_e            fence_mode;
  breach_action_e         breach_action;
  int unsigned            outside_cnt;
  bit                     breach_flag;

  verdict_t    verdict_q [$];
  pin_t        pin_q [$];
  row_t        rows [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_breach();
    outside_cnt = 0;
    breach_flag = 1'b0;
  endfunction

  function automatic void reset_fence();
    box_lo[0] = XMinRst;
    box_lo[1] = YMinRst;
    box_lo[2] = ZMinRst;
    box_hi[0] = XMaxRst;
    box_hi[1] = YMaxRst;
    box_hi[2] = ZMaxRst;
    fence_mode = ModeDisabled;
    breach_action = ActNone;
    clear_breach();
  endfunction

  function automatic void write_fence_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    case (cfg_reg_e'(idx))
      RegXMin:   box_lo[0] = d;
      RegYMin:   box_lo[1] = d;
      RegZMin:   box_lo[2] = d;
      RegXMax:   box_hi[0] = d;
      RegYMax:   box_hi[1] = d;
      RegZMax:   box_hi[2] = d;
      RegMode:   fence_mode = fence_mode_e'(d[CodeW-1:0]);
      default:   breach_action = breach_action_e'(d[CodeW-1:0]);
    endcase
    clear_breach();
  endfunction

  function automatic verdict_t fence_verdict(sample_t s);
    verdict_t               v;
    logic signed [PosW-1:0] p [3];
    bit                     act;
    p[0] = s.x;
    p[1] = s.y;
    p[2] = s.z;
    act = 1'b0;
    case (fence_mode)
      ModeAlways: v.inside_fence = 1'b0;
      ModeBox: begin
        v.inside_fence = 1'b1;
        for (int a = 0; a < 3; a++) begin
          if (p[a] < box_lo[a] || p[a] > box_hi[a]) v.inside_fence = 1'b0;
        end
      end
      default: v.inside_fence = 1'b1;
    endcase
    if (v.inside_fence) begin
      clear_breach();
    end else if (outside_cnt < BreachTicks) begin
      outside_cnt++;
    end else begin
      breach_flag = 1'b1;
      act = 1'b1;
    end
    v.breached = breach_flag;
    v.block_motors = act && s.flying && breach_action == ActStop;
    v.request_shutdown = act && s.flying && breach_action == ActShutdown;
    return v;
  endfunction

  function automatic void compare_field(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    verdict_t got;
    verdict_t want;
    sample_t  s;
    pin_t     pin;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.inside_fence, result_ch.breached, result_ch.block_motors,
               result_ch.request_shutdown};
        if (verdict_q.size() == 0) begin
          $error("result beat with no sample outstanding");
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          compare_field("inside_fence", want.inside_fence, got.inside_fence);
          compare_field("breached", want.breached, got.breached);
          compare_field("block_motors", want.block_motors, got.block_motors);
          compare_field("request_shutdown", want.request_shutdown, got.request_shutdown);
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        s = {sample_ch.pos_x, sample_ch.pos_y, sample_ch.pos_z, sample_ch.is_flying};
        want = fence_verdict(s);
        if (pin_q.size() != 0) begin
          pin = pin_q.pop_front();
          if (pin.pinned) want = pin.want;
        end
        verdict_q.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) write_fence_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_req != 0) begin
        hold_left = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic drive_sample(sample_t s, bit pinned, verdict_t want);
    pin_t p;
    p.pinned = pinned;
    p.want = want;
    pin_q.push_back(p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.pos_x <= s.x;
    sample_ch.pos_y <= s.y;
    sample_ch.pos_z <= s.z;
    sample_ch.is_flying <= s.flying;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= d;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic void cfg_row(cfg_reg_e r, int v);
    row_t e;
    e.is_cfg = 1'b1;
    e.reg_idx = r;
    e.wdata = CfgDataW'(v);
    e.smp = '0;
    e.pinned = 1'b0;
    e.want = '0;
    rows.push_back(e);
  endfunction

  function automatic void smp_row(int x, int y, int z, bit fly, bit pin, logic [3:0] want);
    row_t e;
    e.is_cfg = 1'b0;
    e.reg_idx = RegXMin;
    e.wdata = '0;
    e.smp = {PosW'(x), PosW'(y), PosW'(z), fly};
    e.pinned = pin;
    e.want = verdict_t'(want);
    rows.push_back(e);
  endfunction

  function automatic logic signed [PosW-1:0] pick_coord(int lo, int hi, bit calm);
    int v;
    if (calm && lo <= hi) begin
      v = lo + int'($urandom_range(0, hi - lo));
    end else begin
      case ($urandom_range(0, 9))
        0: v = lo;
        1: v = hi;
        2: v = lo - 1 - int'($urandom_range(0, 3));
        3: v = hi + 1 + int'($urandom_range(0, 3));
        4: v = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
        default: v = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : lo;
      endcase
    end
    if (v < PosMin) v = PosMin;
    if (v > PosMax) v = PosMax;
    return PosW'(v);
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    bit      calm;
    calm = $urandom_range(0, 1);
    s.x = pick_coord(box_lo[0], box_hi[0], calm);
    s.y = pick_coord(box_lo[1], box_hi[1], calm);
    s.z = pick_coord(box_lo[2], box_hi[2], calm);
    s.flying = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic randomize_fence(bit extreme);
    int          lo;
    int          hi;
    int          t;
    fence_mode_e m;
    for (int a = 0; a < 3; a++) begin
      lo = int'($urandom_range(0, 20000)) - 10000;
      hi = lo + int'($urandom_range(0, 4000));
      case ($urandom_range(0, 9))
        0: lo = PosMin;
        1: hi = PosMax;
        2: begin
          t = lo;
          lo = hi + 1;
          hi = t;
        end
        3: begin
          lo = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
          hi = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
        end
        default: ;
      endcase
      if (extreme) begin
        lo = PosMin;
        hi = PosMax;
      end
      write_reg(cfg_reg_e'(a), CfgDataW'(lo));
      write_reg(cfg_reg_e'(a + 3), CfgDataW'(hi));
    end
    case ($urandom_range(0, 9))
      0: m = ModeDisabled;
      1: m = ModeUnlimited;
      2, 3: m = ModeAlways;
      default: m = ModeBox;
    endcase
    if (extreme) m = ModeBox;
    write_reg(RegMode, CfgDataW'(m));
    write_reg(RegAction, CfgDataW'(breach_action_e'($urandom_range(0, 3))));
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned seg;
    int unsigned n;
    rst_ni = 1'b0;
    sample_ch.valid = 1'b0;
    sample_ch.pos_x = '0;
    sample_ch.pos_y = '0;
    sample_ch.pos_z = '0;
    sample_ch.is_flying = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    reset_fence();

    smp_row(PosMin, PosMax, 0, 1'b1, 1'b1, 4'b1000);
    smp_row(0, 0, 0, 1'b0, 1'b0, 4'b0000);
    cfg_row(RegMode, ModeAlways);
    cfg_row(RegAction, ActStop);
    smp_row(5, 5, 5, 1'b1, 1'b1, 4'b0000);
    smp_row(5, 5, 5, 1'b1, 1'b1, 4'b0000);
    smp_row(5, 5, 5, 1'b1, 1'b1, 4'b0110);
    smp_row(5, 5, 5, 1'b0, 1'b1, 4'b0100);
    smp_row(5, 5, 5, 1'b1, 1'b1, 4'b0110);
    cfg_row(RegAction, ActShutdown);
    smp_row(-7, 3, 9, 1'b1, 1'b1, 4'b0000);
    smp_row(-7, 3, 9, 1'b1, 1'b1, 4'b0000);
    smp_row(-7, 3, 9, 1'b1, 1'b1, 4'b0101);
    cfg_row(RegMode, ModeDisabled);
    smp_row(PosMax, PosMin, PosMax, 1'b1, 1'b1, 4'b1000);
    cfg_row(RegMode, ModeUnlimited);
    cfg_row(RegAction, ActLand);
    smp_row(PosMin, PosMin, PosMin, 1'b1, 1'b1, 4'b1000);
    cfg_row(RegMode, ModeBox);
    smp_row(1024, -1024, 0, 1'b1, 1'b1, 4'b1000);
    smp_row(1025, 0, 0, 1'b1, 1'b1, 4'b0000);
    smp_row(0, -1025, 0, 1'b1, 1'b1, 4'b0000);
    smp_row(-1025, 1024, 0, 1'b1, 1'b1, 4'b0100);
    smp_row(0, 0, PosMin, 1'b1, 1'b1, 4'b1000);
    cfg_row(RegXMin, 100);
    cfg_row(RegXMax, -100);
    smp_row(0, 0, 0, 1'b1, 1'b1, 4'b0000);
    cfg_row(RegXMin, PosMin);
    cfg_row(RegXMax, PosMax);
    cfg_row(RegYMin, PosMin);
    cfg_row(RegYMax, PosMax);
    smp_row(PosMin, PosMin, PosMin, 1'b1, 1'b1, 4'b1000);
    smp_row(PosMax, PosMax, PosMax, 1'b0, 1'b1, 4'b1000);
    cfg_row(RegZMin, 0);
    cfg_row(RegZMax, 0);
    smp_row(0, 0, -1, 1'b1, 1'b1, 4'b0000);
    smp_row(0, 0, 1, 1'b1, 1'b0, 4'b0000);
    smp_row(0, 0, 0, 1'b1, 1'b1, 4'b1000);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].wdata);
      end else begin
        drive_sample(rows[i].smp, rows[i].pinned, rows[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 37 : 0;
      sent = 0;
      seg = 0;
      while (sent < PhaseBeats) begin
        settle();
        randomize_fence(seg == 0);
        if (ph == 2 && seg == 1) recv_hold_req = LongHold;
        n = $urandom_range(10, 60);
        repeat (n) begin
          drive_sample(pick_sample(), 1'b0, '0);
          sent++;
        end
        seg++;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
